@@ sv/plru_pkg.sv @@
// Shared types, constants and the factorial table for the permutation rank/unrank block.
`default_nettype none
package plru_pkg;

  localparam int unsigned MaxTilesDefault = 16;
  localparam int unsigned RankW = 45;
  localparam int unsigned ValW = 4;
  localparam int unsigned CfgW = 5;
  localparam int unsigned CntW = 5;
  localparam logic [RankW-1:0] RankMask = {RankW{1'b1}};

  // Command word handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_RANK_DONE = 2'd0,
    CMD_UNRANK    = 2'd1,
    CMD_ERROR     = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [RankW-1:0] rank;
    logic [ValW-1:0]  blank;
    logic [CntW-1:0]  n;
  } cmd_t;

  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_DIV  = 2'd1,
    BS_PICK = 2'd2
  } back_state_e;

  // Factorial table, 64 bits wide to hold 20!.
  function automatic logic [63:0] fact(input logic [CntW-1:0] k);
    logic [63:0] r;
    begin
      case (k)
        5'd0:  r = 64'd1;
        5'd1:  r = 64'd1;
        5'd2:  r = 64'd2;
        5'd3:  r = 64'd6;
        5'd4:  r = 64'd24;
        5'd5:  r = 64'd120;
        5'd6:  r = 64'd720;
        5'd7:  r = 64'd5040;
        5'd8:  r = 64'd40320;
        5'd9:  r = 64'd362880;
        5'd10: r = 64'd3628800;
        5'd11: r = 64'd39916800;
        5'd12: r = 64'd479001600;
        5'd13: r = 64'd6227020800;
        5'd14: r = 64'd87178291200;
        5'd15: r = 64'd1307674368000;
        5'd16: r = 64'd20922789888000;
        5'd17: r = 64'd355687428096000;
        5'd18: r = 64'd6402373705728000;
        5'd19: r = 64'd121645100408832000;
        5'd20: r = 64'd2432902008176640000;
        default: r = 64'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/plru_front.sv @@
// Front end: takes items, stores rank loads, builds rank sums and classifies unrank requests.
`default_nettype none
module plru_front #(
  parameter int unsigned MaxTiles = plru_pkg::MaxTilesDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [plru_pkg::CfgW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        mode_i,
  input  wire logic [plru_pkg::ValW-1:0]   element_value_i,
  input  wire logic [plru_pkg::RankW-1:0]  rank_value_i,
  output logic                             cmd_valid_o,
  input  wire logic                        cmd_stall_i,
  output plru_pkg::cmd_t                   cmd_o
);

  localparam int unsigned IdxW = $clog2(MaxTiles);

  logic [plru_pkg::CfgW-1:0] tiles_q;
  logic [plru_pkg::CntW-1:0] n_eff;
  logic [plru_pkg::ValW-1:0] store_q [MaxTiles];
  logic [plru_pkg::CntW-1:0] load_q;
  logic [plru_pkg::CntW-1:0] p;
  logic [plru_pkg::RankW-1:0] acc_q;
  // Scan of earlier positions for one new element.
  logic                      scan_q;
  logic [plru_pkg::CntW-1:0] j_q;
  logic [plru_pkg::ValW-1:0] v_q;
  logic                      blank_found_q;
  logic [plru_pkg::ValW-1:0] blank_q;
  logic                      emit_q;
  logic                      out_v_q;
  plru_pkg::cmd_t            out_q;
  logic                      accept;
  logic [63:0]               fj;
  logic [63:0]               fn;

  // Clamp the configured length to the supported range.
  always_comb begin
    if (tiles_q < plru_pkg::CfgW'(2)) begin
      n_eff = plru_pkg::CntW'(2);
    end else if (32'(tiles_q) > MaxTiles) begin
      n_eff = plru_pkg::CntW'(MaxTiles);
    end else begin
      n_eff = tiles_q;
    end
  end

  assign p = (load_q >= n_eff) ? '0 : load_q;
  assign in_stall_o = scan_q || emit_q || out_v_q;
  assign accept = in_valid_i && !in_stall_o;
  assign fj = plru_pkg::fact(n_eff - 5'd1 - j_q);
  assign fn = plru_pkg::fact(n_eff);
  assign cmd_valid_o = out_v_q;
  assign cmd_o = out_q;

  // Element store is written on each accepted rank transaction.
  always_ff @(posedge clk_i) begin
    if (accept && !mode_i) begin
      store_q[p[IdxW-1:0]] <= element_value_i;
    end
  end

  // Control: one earlier position is compared per cycle while no configuration write is made.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_q <= plru_pkg::CfgW'(16);
      load_q <= '0;
      acc_q <= '0;
      scan_q <= 1'b0;
      emit_q <= 1'b0;
      out_v_q <= 1'b0;
      j_q <= '0;
      v_q <= '0;
      blank_found_q <= 1'b0;
      blank_q <= '0;
      out_q <= '0;
    end else begin
      if (out_v_q && !cmd_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        tiles_q <= cfg_data_i;
        load_q <= '0;
        acc_q <= '0;
      end else if (accept) begin
        if (mode_i) begin
          load_q <= '0;
          acc_q <= '0;
          out_v_q <= 1'b1;
          out_q.rank <= rank_value_i - 45'd1;
          out_q.blank <= '0;
          out_q.n <= n_eff;
          if (rank_value_i == '0 || {19'd0, rank_value_i} > fn) begin
            out_q.cmd <= plru_pkg::CMD_ERROR;
          end else begin
            out_q.cmd <= plru_pkg::CMD_UNRANK;
          end
        end else begin
          v_q <= element_value_i;
          j_q <= '0;
          load_q <= p + 5'd1;
          if (p == '0) begin
            blank_found_q <= (element_value_i == '0);
            blank_q <= '0;
          end else if (!blank_found_q && element_value_i == '0) begin
            blank_found_q <= 1'b1;
            blank_q <= p[plru_pkg::ValW-1:0];
          end
          scan_q <= (p != '0);
          emit_q <= (p == '0) && (p + 5'd1 >= n_eff);
        end
      end else if (scan_q) begin
        if (store_q[j_q[IdxW-1:0]] > v_q) begin
          acc_q <= acc_q + fj[plru_pkg::RankW-1:0];
        end
        j_q <= j_q + 5'd1;
        if (j_q + 5'd1 >= load_q - 5'd1) begin
          scan_q <= 1'b0;
          emit_q <= (load_q >= n_eff);
        end
      end else if (emit_q) begin
        emit_q <= 1'b0;
        out_v_q <= 1'b1;
        out_q.cmd <= plru_pkg::CMD_RANK_DONE;
        out_q.rank <= acc_q + 45'd1;
        out_q.blank <= blank_found_q ? blank_q : '0;
        out_q.n <= n_eff;
        load_q <= '0;
        acc_q <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/plru_queue.sv @@
// Two-entry command queue between the front end and the back end.
`default_nettype none
module plru_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_stall_o,
  input  wire plru_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  wire logic     rd_stall_i,
  output plru_pkg::cmd_t rd_data_o
);

  plru_pkg::cmd_t mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop = rd_valid_o && !rd_stall_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ sv/plru_back.sv @@
// Back end: emits rank and error results and unranks with factorial division, one digit per pass.
`default_nettype none
module plru_back #(
  parameter int unsigned MaxTiles = plru_pkg::MaxTilesDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_stall_o,
  input  wire plru_pkg::cmd_t              cmd_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [plru_pkg::RankW-1:0]       rank_result_o,
  output logic [plru_pkg::ValW-1:0]        tile_value_o,
  output logic [plru_pkg::ValW-1:0]        position_o,
  output logic [plru_pkg::ValW-1:0]        blank_position_o,
  output logic                             last_o,
  output logic                             error_o
);

  plru_pkg::back_state_e state_q, state_d;
  logic [plru_pkg::RankW-1:0] h_q;
  logic [plru_pkg::CntW-1:0]  n_q;
  logic [plru_pkg::CntW-1:0]  i_q;
  logic [plru_pkg::CntW-1:0]  k_q;
  logic [31:0]                unused_q;
  logic [63:0]                f_full;
  logic [plru_pkg::RankW-1:0] f;
  logic                       blank_found_q;
  logic [plru_pkg::ValW-1:0]  blank_q;
  logic                       out_v_q;
  logic                       take;
  logic                       ostall;
  logic                       out_load;
  logic [plru_pkg::CntW-1:0]  val;
  logic [plru_pkg::CntW-1:0]  seen;
  logic                       hit;

  logic [plru_pkg::RankW-1:0] rr_q;
  logic [plru_pkg::ValW-1:0]  tv_q, pos_q, bp_q;
  logic                       last_q, err_q;

  assign ostall = out_v_q && out_stall_i;
  assign take = cmd_valid_i && (state_q == plru_pkg::BS_IDLE) && !ostall;
  assign cmd_stall_o = !take;
  assign f_full = plru_pkg::fact(n_q - 5'd1 - i_q);
  assign f = f_full[plru_pkg::RankW-1:0];

  // A new result is loaded for a rank or error command, or for each picked digit.
  assign out_load = (take && cmd_i.cmd != plru_pkg::CMD_UNRANK) ||
                    (state_q == plru_pkg::BS_PICK && !ostall);

  // Select the k-th still-unused value.
  always_comb begin
    val = '0;
    seen = '0;
    hit = 1'b0;
    for (int b = 0; b < MaxTiles; b++) begin
      if (!hit && unused_q[b]) begin
        if (seen == k_q) begin
          val = plru_pkg::CntW'(b);
          hit = 1'b1;
        end
        seen = seen + 5'd1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      plru_pkg::BS_IDLE: begin
        if (take && cmd_i.cmd == plru_pkg::CMD_UNRANK) state_d = plru_pkg::BS_DIV;
      end
      plru_pkg::BS_DIV: begin
        if (h_q < f) state_d = plru_pkg::BS_PICK;
      end
      plru_pkg::BS_PICK: begin
        if (!ostall) begin
          state_d = (i_q + 5'd1 >= n_q) ? plru_pkg::BS_IDLE : plru_pkg::BS_DIV;
        end
      end
      default: state_d = plru_pkg::BS_IDLE;
    endcase
  end

  // Outputs are driven from the result register.
  always_comb begin
    out_valid_o = out_v_q;
    rank_result_o = rr_q;
    tile_value_o = tv_q;
    position_o = pos_q;
    blank_position_o = bp_q;
    last_o = last_q;
    error_o = err_q;
  end

  // Datapath: the quotient digit is found by repeated subtraction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plru_pkg::BS_IDLE;
      out_v_q <= 1'b0;
      h_q <= '0;
      n_q <= '0;
      i_q <= '0;
      k_q <= '0;
      unused_q <= '1;
      blank_found_q <= 1'b0;
      blank_q <= '0;
      rr_q <= '0;
      tv_q <= '0;
      pos_q <= '0;
      bp_q <= '0;
      last_q <= 1'b0;
      err_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        plru_pkg::BS_IDLE: begin
          if (take) begin
            if (cmd_i.cmd == plru_pkg::CMD_UNRANK) begin
              h_q <= cmd_i.rank;
              n_q <= cmd_i.n;
              i_q <= '0;
              k_q <= '0;
              unused_q <= 32'((33'd1 << cmd_i.n) - 33'd1);
              blank_found_q <= 1'b0;
              blank_q <= '0;
            end else begin
              rr_q <= (cmd_i.cmd == plru_pkg::CMD_RANK_DONE) ? cmd_i.rank : '0;
              tv_q <= '0;
              pos_q <= '0;
              bp_q <= (cmd_i.cmd == plru_pkg::CMD_RANK_DONE) ? cmd_i.blank : '0;
              last_q <= 1'b1;
              err_q <= (cmd_i.cmd == plru_pkg::CMD_ERROR);
            end
          end
        end
        plru_pkg::BS_DIV: begin
          if (h_q >= f) begin
            h_q <= h_q - f;
            k_q <= k_q + 5'd1;
          end
        end
        plru_pkg::BS_PICK: begin
          if (!ostall) begin
            unused_q[val] <= 1'b0;
            rr_q <= '0;
            tv_q <= val[plru_pkg::ValW-1:0];
            pos_q <= i_q[plru_pkg::ValW-1:0];
            err_q <= 1'b0;
            if (!blank_found_q && val == '0) begin
              blank_found_q <= 1'b1;
              blank_q <= i_q[plru_pkg::ValW-1:0];
            end
            if (i_q + 5'd1 >= n_q) begin
              last_q <= 1'b1;
              bp_q <= (!blank_found_q && val == '0) ? i_q[plru_pkg::ValW-1:0]
                      : (blank_found_q ? blank_q : '0);
            end else begin
              last_q <= 1'b0;
              bp_q <= '0;
            end
            i_q <= i_q + 5'd1;
            k_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/permutation_lex_rank_unrank.sv @@
// Element p of a rank load stalls the input while the p earlier values are compared. After the last
// element's comparisons, the rank result passes through the emit step, the front end's output register,
// the command queue and the back end's result register. Unrank: each tile is found in turn by
// repeated subtraction of a factorial, k being that quotient digit (at most n-1-i), then a pick of
// the k-th unused value. Reset clears load state and the queue; the tile count resets to 16.
// Top level: front end, command queue and back end.
`default_nettype none
module permutation_lex_rank_unrank #(
  parameter int unsigned MaxTiles = plru_pkg::MaxTilesDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [plru_pkg::CfgW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        mode_i,
  input  wire logic [plru_pkg::ValW-1:0]   element_value_i,
  input  wire logic [plru_pkg::RankW-1:0]  rank_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [plru_pkg::RankW-1:0]       rank_result_o,
  output logic [plru_pkg::ValW-1:0]        tile_value_o,
  output logic [plru_pkg::ValW-1:0]        position_o,
  output logic [plru_pkg::ValW-1:0]        blank_position_o,
  output logic                             last_o,
  output logic                             error_o
);

  logic           f_valid, f_stall, b_valid, b_stall;
  plru_pkg::cmd_t f_cmd, b_cmd;

  plru_front #(.MaxTiles(MaxTiles)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .mode_i, .element_value_i, .rank_value_i,
    .cmd_valid_o(f_valid), .cmd_stall_i(f_stall), .cmd_o(f_cmd)
  );

  plru_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_cmd)
  );

  plru_back #(.MaxTiles(MaxTiles)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_stall_o(b_stall), .cmd_i(b_cmd),
    .out_valid_o, .out_stall_i, .rank_result_o, .tile_value_o, .position_o,
    .blank_position_o, .last_o, .error_o
  );

endmodule
`default_nettype wire
